// File: rtl/core/u16st_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16st_pkg
// Types and constants shared by the UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
package u16st_pkg;

  localparam int unsigned ValueW = 21;
  localparam int unsigned AddrW  = 3;

  localparam logic RegDirection  = 1'b0;
  localparam logic RegErrorValue = 1'b1;

  localparam logic [ValueW-1:0] ErrorValueReset = 21'h00FFFD;
  localparam logic [31:0]       MaxCodePoint    = 32'h0010FFFF;
  localparam logic [31:0]       SurrogateFirst  = 32'h0000D800;
  localparam logic [31:0]       SurrogateLast   = 32'h0000DFFF;
  localparam logic [31:0]       NonCharA        = 32'h0000FFFE;
  localparam logic [31:0]       NonCharB        = 32'h0000FFFF;
  localparam logic [31:0]       SuppBase        = 32'h00010000;
  localparam logic [5:0]        HighTag         = 6'b110110;
  localparam logic [5:0]        LowTag          = 6'b110111;

  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } dir_e;

  typedef struct packed {
    logic [31:0] in_word;
    logic        end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [ValueW-1:0] out_value;
    logic              is_error;
    logic              run_last;
    logic              stream_last;
  } out_req_t;

  // Up to two results produced by one input request.
  typedef struct packed {
    logic [ValueW-1:0] value0;
    logic              err0;
    logic [ValueW-1:0] value1;
    logic              err1;
    logic              two;
    logic              eos;
  } job_t;

endpackage

// File: rtl/core/u16st_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16st_front
// Accepts requests, classifies them and builds a job of up to two results.
// Holds the pending high surrogate in decode mode.
// ----------------------------------------------------------------------------
module u16st_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  u16st_pkg::in_req_t   req_i,
  input  u16st_pkg::dir_e      dir_i,
  input  logic [20:0]          err_value_i,
  output logic                 push_o,
  output u16st_pkg::job_t      job_o
);
  import u16st_pkg::*;

  logic [9:0]        pend_bits_q, pend_bits_d;
  logic              pend_valid_q, pend_valid_d;
  logic [31:0]       word;
  logic [15:0]       unit;
  logic              is_low, is_high, nonchar;
  logic              enc_bad;
  logic [ValueW-1:0] supp;
  logic [ValueW-1:0] pair_cp;
  logic              q_has, q_err;
  logic [ValueW-1:0] q_val;
  logic              n_any;

  assign word    = req_i.in_word;
  assign unit    = word[15:0];
  assign is_low  = (unit[15:10] == LowTag);
  assign is_high = (unit[15:10] == HighTag);
  assign nonchar = ({16'h0000, unit} == NonCharA) || ({16'h0000, unit} == NonCharB);
  assign enc_bad = (word > MaxCodePoint) || (word == NonCharA) || (word == NonCharB) ||
                   ((word >= SurrogateFirst) && (word <= SurrogateLast));
  assign supp    = word[ValueW-1:0] - SuppBase[ValueW-1:0];
  assign pair_cp = {1'b0, pend_bits_q, unit[9:0]} + SuppBase[ValueW-1:0];

  always_comb begin
    job_o        = '0;
    job_o.eos    = req_i.end_of_stream;
    n_any        = 1'b0;
    q_has        = 1'b0;
    q_err        = 1'b0;
    q_val        = '0;
    pend_bits_d  = pend_bits_q;
    pend_valid_d = pend_valid_q;
    if (dir_i == DirEncode) begin
      n_any        = 1'b1;
      pend_bits_d  = '0;
      pend_valid_d = 1'b0;
      if (enc_bad) begin
        job_o.value0 = err_value_i;
        job_o.err0   = 1'b1;
      end else if (word < SuppBase) begin
        job_o.value0 = word[ValueW-1:0];
      end else begin
        job_o.value0 = {5'b0, HighTag, supp[19:10]};
        job_o.value1 = {5'b0, LowTag, supp[9:0]};
        job_o.two    = 1'b1;
      end
    end else begin
      pend_bits_d  = '0;
      pend_valid_d = 1'b0;
      // result caused by the unit itself, when not completing a pair
      if (nonchar || is_low) begin
        q_has = 1'b1;
        q_err = 1'b1;
        q_val = err_value_i;
      end else if (is_high) begin
        if (req_i.end_of_stream) begin
          q_has = 1'b1;
          q_err = 1'b1;
          q_val = err_value_i;
        end else begin
          pend_bits_d  = unit[9:0];
          pend_valid_d = 1'b1;
        end
      end else begin
        q_has = 1'b1;
        q_val = {5'b0, unit};
      end
      if (pend_valid_q && is_low) begin
        n_any        = 1'b1;
        job_o.value0 = pair_cp;
        pend_bits_d  = '0;
        pend_valid_d = 1'b0;
      end else if (pend_valid_q) begin
        n_any        = 1'b1;
        job_o.value0 = err_value_i;
        job_o.err0   = 1'b1;
        job_o.value1 = q_val;
        job_o.err1   = q_err;
        job_o.two    = q_has;
      end else begin
        n_any        = q_has;
        job_o.value0 = q_val;
        job_o.err0   = q_err;
      end
      if (req_i.end_of_stream) begin
        pend_bits_d  = '0;
        pend_valid_d = 1'b0;
      end
    end
  end

  assign push_o = accept_i && n_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q  <= '0;
      pend_valid_q <= 1'b0;
    end else if (accept_i) begin
      pend_bits_q  <= pend_bits_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule

// File: rtl/core/u16st_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16st_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u16st_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u16st_pkg::job_t  job_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output u16st_pkg::job_t  head_o
);
  import u16st_pkg::*;

  localparam int unsigned Depth = 2;

  job_t       mem_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

// File: rtl/core/u16st_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16st_back
// Walks the results of the queue head job, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module u16st_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  u16st_pkg::job_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u16st_pkg::out_req_t out_req_o
);
  import u16st_pkg::*;

  logic sel_q;
  logic last;
  logic take;

  assign out_valid_o = !empty_i;
  assign last        = !head_i.two || sel_q;
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && last;

  always_comb begin
    out_req_o.out_value   = sel_q ? head_i.value1 : head_i.value0;
    out_req_o.is_error    = sel_q ? head_i.err1 : head_i.err0;
    out_req_o.run_last    = last;
    out_req_o.stream_last = last && head_i.eos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= !last;
    end
  end

endmodule

// File: rtl/core/utf16_stream_transcoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_stream_transcoder_unit
// Streaming UTF-16 encoder/decoder with programmable error value.
// ----------------------------------------------------------------------------
// The block takes one request per cycle and delivers one result per cycle,
// unless the queue is full or the output is stalled. A code point encoded
// as a surrogate pair, or a decode error reported ahead of the current
// unit, yields two results, which the back end delivers one after another
// through its single result port; a two-entry queue between front and back
// lets input continue while results wait.
// Register 0 (address 0) is the direction, 0 encode, 1 decode; register 1
// (address 4) is the 21-bit error value, reset 0xFFFD. Write them idle only.
// ----------------------------------------------------------------------------
module utf16_stream_transcoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u16st_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u16st_pkg::out_req_t out_req_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import u16st_pkg::*;

  dir_e              dir_q;
  logic [ValueW-1:0] err_value_q;
  logic              cfg_wr;
  logic              accept;
  logic              push, pop, full, empty;
  job_t              job, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DirEncode;
      err_value_q <= ErrorValueReset;
    end else if (cfg_wr) begin
      if (paddr[AddrW-1] == RegDirection) begin
        dir_q <= dir_e'(pwdata[0]);
      end else begin
        err_value_q <= pwdata[ValueW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[AddrW-1] == RegErrorValue) begin
      prdata = {11'b0, err_value_q};
    end else begin
      prdata = {31'b0, dir_q};
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u16st_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (in_req_i),
    .dir_i       (dir_q),
    .err_value_i (err_value_q),
    .push_o      (push),
    .job_o       (job)
  );

  u16st_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  u16st_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for utf16_stream_transcoder_unit.
// ----------------------------------------------------------------------------
// A driver feeds code points or UTF-16 units from a queue with random gaps.
// A monitor predicts the results of each accepted request and checks every
// result against them in order, with random output stalls and one long
// hold-off. The registers are set over the APB port between phases: both
// directions, several error values and the extremes.
// ----------------------------------------------------------------------------
module tb;
  import u16st_pkg::*;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_req_t          out_req_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  utf16_stream_transcoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Register shadow and surrogate state of the predictor.
  dir_e              dir_cfg = DirEncode;
  logic [ValueW-1:0] err_cfg = ErrorValueReset;
  logic [9:0]        held_high_bits  = '0;
  logic              held_high_valid = 1'b0;

  in_req_t  word_q[$];
  out_req_t transcoded_q[$];

  int unsigned send_gap_max = 11;
  int unsigned recv_gap_max = 11;
  logic        choke_arm    = 1'b0;

  int unsigned items_sent, results_checked, error_results, stream_ends;
  int unsigned fail_count, reg_writes;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  function automatic void emit(logic [ValueW-1:0] value, logic err);
    out_req_t r;
    r = '0;
    r.out_value = value;
    r.is_error  = err;
    transcoded_q.push_back(r);
  endfunction

  function automatic void transcode_item(in_req_t req);
    int unsigned before_n;
    logic [31:0] cp;
    logic [19:0] off;
    logic [15:0] unit;
    logic        is_lo, is_hi, paired;
    out_req_t    tail;
    before_n = transcoded_q.size();
    if (dir_cfg == DirEncode) begin
      cp = req.in_word;
      held_high_valid = 1'b0;
      held_high_bits  = '0;
      if (cp > MaxCodePoint || cp == NonCharA || cp == NonCharB ||
          (cp >= SurrogateFirst && cp <= SurrogateLast)) begin
        emit(err_cfg, 1'b1);
      end else if (cp < SuppBase) begin
        emit(cp[ValueW-1:0], 1'b0);
      end else begin
        off = 20'(cp - SuppBase);
        emit(ValueW'({HighTag, off[19:10]}), 1'b0);
        emit(ValueW'({LowTag, off[9:0]}), 1'b0);
      end
    end else begin
      unit   = req.in_word[15:0];
      is_lo  = (unit[15:10] == LowTag);
      is_hi  = (unit[15:10] == HighTag);
      paired = 1'b0;
      if (held_high_valid) begin
        if (is_lo) begin
          emit(ValueW'({held_high_bits, unit[9:0]}) + ValueW'(SuppBase), 1'b0);
          paired = 1'b1;
        end else begin
          emit(err_cfg, 1'b1);
        end
        held_high_valid = 1'b0;
        held_high_bits  = '0;
      end
      if (!paired) begin
        if (unit == NonCharA[15:0] || unit == NonCharB[15:0] || is_lo) begin
          emit(err_cfg, 1'b1);
        end else if (is_hi) begin
          if (req.end_of_stream) begin
            emit(err_cfg, 1'b1);
          end else begin
            held_high_bits  = unit[9:0];
            held_high_valid = 1'b1;
          end
        end else begin
          emit(ValueW'(unit), 1'b0);
        end
      end
      if (req.end_of_stream) begin
        held_high_valid = 1'b0;
        held_high_bits  = '0;
      end
    end
    if (transcoded_q.size() > before_n) begin
      tail = transcoded_q.pop_back();
      tail.run_last    = 1'b1;
      tail.stream_last = req.end_of_stream;
      transcoded_q.push_back(tail);
    end
  endfunction

  function automatic void check_result(out_req_t got);
    out_req_t want;
    results_checked++;
    if (got.is_error) error_results++;
    if (got.stream_last) stream_ends++;
    if (transcoded_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      fail_count++;
      return;
    end
    want = transcoded_q.pop_front();
    if (got.out_value !== want.out_value) begin
      $display("%0t: out_value expected %h, got %h", $time, want.out_value, got.out_value);
      fail_count++;
    end
    if (got.is_error !== want.is_error) begin
      $display("%0t: is_error expected %b, got %b", $time, want.is_error, got.is_error);
      fail_count++;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t: run_last expected %b, got %b", $time, want.run_last, got.run_last);
      fail_count++;
    end
    if (got.stream_last !== want.stream_last) begin
      $display("%0t: stream_last expected %b, got %b", $time, want.stream_last,
               got.stream_last);
      fail_count++;
    end
  endfunction

  // Driver
  int unsigned send_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_req_i   <= word_q.pop_front();
        in_valid_i <= 1'b1;
        send_wait  <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor
  int unsigned recv_wait  = 0;
  int unsigned recv_draw  = 0;
  int unsigned choke_left = 0;
  logic        choke_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   <= 0;
      choke_left  <= 0;
      choke_done  <= 1'b0;
    end else begin
      if (in_fire) begin
        transcode_item(in_req_i);
        items_sent++;
      end
      if (out_fire) check_result(out_req_o);
      if (choke_arm && !choke_done) begin
        choke_done  <= 1'b1;
        choke_left  <= 400;
        out_stall_i <= 1'b1;
      end else if (choke_left != 0) begin
        choke_left  <= choke_left - 1;
        out_stall_i <= (choke_left > 1);
      end else if (out_fire) begin
        recv_draw = $urandom_range(0, recv_gap_max);
        recv_wait   <= recv_draw;
        out_stall_i <= (recv_draw != 0);
      end else if (recv_wait > 1) begin
        recv_wait   <= recv_wait - 1;
        out_stall_i <= 1'b1;
      end else begin
        recv_wait   <= 0;
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus
  function automatic void queue_item(logic [31:0] word, logic eos);
    in_req_t r;
    r.in_word       = word;
    r.end_of_stream = eos;
    word_q.push_back(r);
  endfunction

  function automatic logic [31:0] rand_upper(logic [15:0] unit);
    return $urandom_range(0, 1) ? {16'($urandom()), unit} : {16'h0000, unit};
  endfunction

  function automatic int queue_code_point();
    logic [31:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2: cp = $urandom_range(0, 32'hD7FF);
      3:       cp = $urandom_range(32'hE000, 32'hFFFD);
      4, 5, 6: cp = $urandom_range(32'h10000, 32'h10FFFF);
      7:       cp = $urandom_range(32'hD800, 32'hDFFF);
      8:       cp = $urandom_range(32'hFFFE, 32'hFFFF);
      default: cp = $urandom_range(0, 1) ? $urandom() : $urandom_range(32'h110000, 32'h110100);
    endcase
    queue_item(cp, $urandom_range(0, 15) == 0);
    return 1;
  endfunction

  // Mostly well-formed units and pairs, some stray, lone or non-character units.
  function automatic int queue_decode_seq();
    logic [31:0] cp;
    logic [19:0] off;
    logic        eos;
    eos = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 9))
      7: queue_item(rand_upper({LowTag, 10'($urandom())}), eos);
      8: queue_item(rand_upper({HighTag, 10'($urandom())}), eos);
      9: queue_item(rand_upper($urandom_range(0, 1) ? 16'($urandom_range(16'hFFFE, 16'hFFFF))
                                                    : 16'($urandom())), eos);
      default: begin
        if ($urandom_range(0, 1)) begin
          off = 20'($urandom_range(0, 32'hFFFFF));
          queue_item(rand_upper({HighTag, off[19:10]}), 1'b0);
          queue_item(rand_upper({LowTag, off[9:0]}), eos);
          return 2;
        end
        cp = $urandom_range(0, 1) ? $urandom_range(0, 32'hD7FF)
                                  : $urandom_range(32'hE000, 32'hFFFD);
        queue_item(rand_upper(cp[15:0]), eos);
      end
    endcase
    return 1;
  endfunction

  task automatic reg_write(input logic idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegDirection) dir_cfg = dir_e'(data[0]);
    else err_cfg = data[ValueW-1:0];
    reg_writes++;
  endtask

  // Units that only fill the surrogate holder produce nothing, so pad the idle wait.
  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || transcoded_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0]       enc_edges [10];
    dir_e              dir_sel;
    logic [ValueW-1:0] err_sel;
    int                k;
    enc_edges = '{32'h0, 32'hD7FF, 32'hD800, 32'hDFFF, 32'hFFFE,
                  32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000,
                  32'hFFFFFFFF};
    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (enc_edges[i]) queue_item(enc_edges[i], i == 9);
    drain();

    reg_write(RegDirection, 32'(DirDecode));
    reg_write(RegErrorValue, MaxCodePoint);
    queue_item(32'h0041, 1'b0);
    queue_item(32'hD83D, 1'b0);
    queue_item(32'hDE00, 1'b0);
    queue_item(32'hDC00, 1'b0);
    queue_item(32'hFFFE, 1'b0);
    queue_item(32'hFFFF, 1'b0);
    queue_item(32'hD800, 1'b0);
    queue_item(32'hDBFF, 1'b0);
    queue_item(32'hABCD0041, 1'b0);
    queue_item(32'hDBFF, 1'b1);
    queue_item(32'hD800, 1'b0);
    queue_item(32'hFFFFDFFF, 1'b1);
    queue_item(32'hDBFF, 1'b0);
    queue_item(32'hDFFF, 1'b0);
    queue_item(32'hD801, 1'b0);
    drain();
    // encode drops the held high surrogate, so the low unit after it is stray
    reg_write(RegDirection, 32'(DirEncode));
    queue_item(32'h0041, 1'b0);
    drain();
    reg_write(RegDirection, 32'(DirDecode));
    reg_write(RegErrorValue, 32'h0);
    queue_item(32'hDC00, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      dir_sel = dir_e'(ph % 2);
      case (ph % 4)
        0:       err_sel = '0;
        1:       err_sel = MaxCodePoint[ValueW-1:0];
        2:       err_sel = ErrorValueReset;
        default: err_sel = ValueW'($urandom_range(0, MaxCodePoint));
      endcase
      reg_write(RegDirection, {31'($urandom()), 1'(dir_sel)});
      reg_write(RegErrorValue, {11'($urandom()), err_sel});
      send_gap_max = (ph == 2 || ph == 3 || ph == 7) ? 0 : 11;
      recv_gap_max = (ph == 4 || ph == 7) ? 0 : 11;
      k = 0;
      while (k < 240) k += (dir_sel == DirEncode) ? queue_code_point() : queue_decode_seq();
      if (ph == 3) choke_arm = 1'b1;
      drain();
    end

    $display("Sent %0d requests over %0d register writes, both directions, one long hold-off",
             items_sent, reg_writes);
    $display("Checked %0d results: %0d error values, %0d stream ends, %0d mismatches",
             results_checked, error_results, stream_ends, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/u16st_pkg.sv
rtl/core/u16st_front.sv
rtl/core/u16st_queue.sv
rtl/core/u16st_back.sv
rtl/core/utf16_stream_transcoder_unit.sv
verif/tb.sv
